/* rtl/fwep_pkg.sv */
// Package for the flash write/erase planner.
// Holds default parameters, command and operation codes, controller states and
// the command/status structs shared by the controller and the datapath.
package fwep_pkg;

    localparam int PAGE_BYTES_DEF   = 256;
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int ADDRESS_BITS_DEF = 25;
    localparam int MAX_RESULTS      = 17;
    localparam int RC_W             = $clog2(MAX_RESULTS + 1);

    localparam int FIELD_ADDR_W  = 25;
    localparam int FIELD_LEN_W   = 16;
    localparam int FIELD_BYTE_W  = 8;
    localparam int FIELD_CNT_W   = 9;
    localparam int CAPACITY_W    = 26;

    localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 26'd16777216;

    localparam logic [1:0] CMD_ERASE   = 2'd0;
    localparam logic [1:0] CMD_PROGRAM = 2'd1;
    localparam logic [1:0] CMD_REJECT  = 2'd2;

    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed
    {
        logic accept;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic seg_close;
        logic emit_last;
        logic slot_free;
    } dp_status_t;

endpackage

/* rtl/flash_write_erase_planner.sv */
// Top level of the flash write/erase planner.
// Unpacks the stream buses and joins fwep_ctrl and fwep_datapath; uses fwep_pkg.
//
// Channel   Direction  Payload
// s_axis    in         tuser: operation; tdata: start_address, length, new_byte, old_byte
// m_axis    out        tuser: command; tlast: last; tdata: flash_address, byte_count
// cfg       in         cfg_we, cfg_wdata: capacity_bytes
//
// A begin transaction or a data transaction that does not close a segment leaves the controller idle.
// A data transaction that closes a segment is followed by its plan, one command per cycle
// from the plan generator (up to 17 with default sizes); no input is taken until the last
// command is in the output register. Low m_tready stretches each command by the stall.
// Reset clears the request state and restores capacity_bytes to 16 MiB.
module flash_write_erase_planner
#(
    parameter int PAGE_BYTES   = fwep_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = fwep_pkg::SECTOR_BYTES_DEF,
    parameter int ADDRESS_BITS = fwep_pkg::ADDRESS_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [25:0] cfg_wdata,     // capacity_bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // start_address, length, new_byte, old_byte, zero pad
    input  logic [0:0]  s_tuser,       // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // flash_address, byte_count, zero pad
    output logic [1:0]  m_tuser,       // command
    output logic        m_tlast
);
    import fwep_pkg::*;

    ctrl_cmd_t              cmd;
    dp_status_t             status;
    logic [FIELD_ADDR_W-1:0] flash_address;
    logic [FIELD_CNT_W-1:0] byte_count;

    fwep_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fwep_datapath
    #(
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .operation     (s_tuser[0]),
        .start_address (s_tdata[24:0]),
        .length        (s_tdata[40:25]),
        .new_byte      (s_tdata[48:41]),
        .old_byte      (s_tdata[56:49]),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .command       (m_tuser),
        .flash_address (flash_address),
        .byte_count    (byte_count),
        .last          (m_tlast)
    );

    assign m_tdata = {6'd0, byte_count, flash_address};

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> m_tvalid)
        else $error("Emitted command did not reach the output register.");

    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[0] == OP_DATA) && status.seg_close) |=> !s_tready)
        else $error("Input taken while a segment plan is pending.");

    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == CMD_REJECT)) |-> m_tlast)
        else $error("Rejected request not marked as last.");

endmodule

/* rtl/fwep_ctrl.sv */
// Controller state machine of the flash write/erase planner.
// Decides when an input transaction is taken and when plan commands are emitted.
// Depends on fwep_pkg.
module fwep_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fwep_pkg::dp_status_t status,
    output fwep_pkg::ctrl_cmd_t  cmd
);
    import fwep_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && status.seg_close)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.emit && status.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = status.slot_free;
                cmd.accept = in_valid && status.slot_free;
            end
            ST_EMIT:
            begin
                cmd.emit = status.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/fwep_datapath.sv */
// Datapath of the flash write/erase planner: request and segment state,
// plan generator and the output register. Depends on fwep_pkg.
module fwep_datapath
#(
    parameter int PAGE_BYTES   = fwep_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = fwep_pkg::SECTOR_BYTES_DEF,
    parameter int ADDRESS_BITS = fwep_pkg::ADDRESS_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [fwep_pkg::CAPACITY_W-1:0]       cfg_wdata,
    input  logic                                  operation,
    input  logic [fwep_pkg::FIELD_ADDR_W-1:0]     start_address,
    input  logic [fwep_pkg::FIELD_LEN_W-1:0]      length,
    input  logic [fwep_pkg::FIELD_BYTE_W-1:0]     new_byte,
    input  logic [fwep_pkg::FIELD_BYTE_W-1:0]     old_byte,
    input  fwep_pkg::ctrl_cmd_t                   cmd,
    output fwep_pkg::dp_status_t                  status,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [1:0]                            command,
    output logic [fwep_pkg::FIELD_ADDR_W-1:0]     flash_address,
    output logic [fwep_pkg::FIELD_CNT_W-1:0]      byte_count,
    output logic                                  last
);
    import fwep_pkg::*;

    localparam int AW    = ADDRESS_BITS;
    localparam int SEC_W = $clog2(SECTOR_BYTES);
    localparam int PG_W  = $clog2(PAGE_BYTES);
    localparam int CNT_W = SEC_W + 1;
    localparam int CW    = (CNT_W > PG_W + 1) ? CNT_W : PG_W + 1;
    localparam logic [AW-1:0]    SECTOR_MASK = AW'(SECTOR_BYTES - 1);
    localparam logic [RC_W-1:0]  RC_FINAL    = RC_W'(MAX_RESULTS - 1);

    logic [CAPACITY_W-1:0]  capacity_reg;
    logic                   active_reg;
    logic [AW-1:0]          cur_addr_reg;
    logic [FIELD_LEN_W-1:0] left_reg;
    logic [AW-1:0]          seg_start_reg;
    logic [CNT_W-1:0]       seg_cnt_reg;
    logic                   need_reg;
    logic [AW-1:0]          em_addr_reg;
    logic [CNT_W-1:0]       em_left_reg;
    logic                   em_erase_reg;
    logic [RC_W-1:0]        rc_reg;
    logic                   out_valid_reg;
    logic [1:0]             out_cmd_reg;
    logic [FIELD_ADDR_W-1:0] out_addr_reg;
    logic [FIELD_CNT_W-1:0] out_cnt_reg;
    logic                   out_last_reg;

    logic [31:0]            start_ext;
    logic [AW-1:0]          start_aw;
    logic                   reject;
    logic                   load_out;
    logic                   need_next;
    logic [CNT_W-1:0]       cnt_inc;
    logic [AW-1:0]          addr_inc;
    logic [FIELD_LEN_W-1:0] left_dec;
    logic                   close;
    logic [CW-1:0]          room;
    logic [CW-1:0]          left_cw;
    logic [CW-1:0]          chunk;
    logic [31:0]            chunk_ext;
    logic [31:0]            em_addr_ext;
    logic                   last_erase;
    logic                   last_prog;

    assign start_ext = 32'(start_address);
    assign start_aw  = start_ext[AW-1:0];
    assign reject    = (length == '0) || ({1'b0, start_address} > capacity_reg);
    assign load_out  = cmd.emit || (cmd.accept && (operation == OP_BEGIN) && reject);

    assign need_next = need_reg || ((~old_byte & new_byte) != '0);
    assign cnt_inc   = seg_cnt_reg + 1'b1;
    assign addr_inc  = cur_addr_reg + 1'b1;
    assign left_dec  = left_reg - 1'b1;
    assign close     = (left_dec == '0) || (addr_inc[SEC_W-1:0] == '0);

    assign room        = CW'(PAGE_BYTES) - CW'(em_addr_reg[PG_W-1:0]);
    assign left_cw     = CW'(em_left_reg);
    assign chunk       = (left_cw < room) ? left_cw : room;
    assign chunk_ext   = 32'(chunk);
    assign em_addr_ext = 32'(em_addr_reg);
    assign last_erase  = (rc_reg == RC_FINAL);
    assign last_prog   = (left_cw == chunk) || (rc_reg == RC_FINAL);

    assign status.seg_close = (operation == OP_DATA) && active_reg && close;
    assign status.emit_last = em_erase_reg ? last_erase : last_prog;
    assign status.slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAPACITY_RESET;
            active_reg    <= 1'b0;
            cur_addr_reg  <= '0;
            left_reg      <= '0;
            seg_start_reg <= '0;
            seg_cnt_reg   <= '0;
            need_reg      <= 1'b0;
            em_erase_reg  <= 1'b0;
            rc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.accept)
            begin
                if (operation == OP_BEGIN)
                begin
                    if (reject)
                    begin
                        active_reg    <= 1'b0;
                    end
                    else
                    begin
                        active_reg    <= 1'b1;
                        cur_addr_reg  <= start_aw;
                        left_reg      <= length;
                        seg_start_reg <= start_aw;
                        seg_cnt_reg   <= '0;
                        need_reg      <= 1'b0;
                    end
                end
                else if (active_reg)
                begin
                    cur_addr_reg <= addr_inc;
                    left_reg     <= left_dec;
                    if (close)
                    begin
                        em_erase_reg <= need_next;
                        rc_reg       <= '0;
                        if (left_dec == '0)
                        begin
                            active_reg  <= 1'b0;
                            seg_cnt_reg <= cnt_inc;
                            need_reg    <= need_next;
                        end
                        else
                        begin
                            seg_start_reg <= addr_inc;
                            seg_cnt_reg   <= '0;
                            need_reg      <= 1'b0;
                        end
                    end
                    else
                    begin
                        seg_cnt_reg <= cnt_inc;
                        need_reg    <= need_next;
                    end
                end
            end

            if (cmd.emit)
            begin
                rc_reg        <= rc_reg + 1'b1;
                if (em_erase_reg)
                begin
                    em_erase_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (operation == OP_BEGIN) && reject)
        begin
            out_cmd_reg  <= CMD_REJECT;
            out_addr_reg <= start_address;
            out_cnt_reg  <= '0;
            out_last_reg <= 1'b1;
        end

        if (cmd.accept && (operation == OP_DATA) && active_reg && close)
        begin
            if (need_next)
            begin
                em_addr_reg <= seg_start_reg & ~SECTOR_MASK;
                em_left_reg <= CNT_W'(SECTOR_BYTES);
            end
            else
            begin
                em_addr_reg <= seg_start_reg;
                em_left_reg <= cnt_inc;
            end
        end

        if (cmd.emit)
        begin
            out_addr_reg <= em_addr_ext[FIELD_ADDR_W-1:0];
            if (em_erase_reg)
            begin
                out_cmd_reg  <= CMD_ERASE;
                out_cnt_reg  <= '0;
                out_last_reg <= last_erase;
            end
            else
            begin
                out_cmd_reg  <= CMD_PROGRAM;
                out_cnt_reg  <= chunk_ext[FIELD_CNT_W-1:0];
                out_last_reg <= last_prog;
                em_addr_reg  <= em_addr_reg + AW'(chunk);
                em_left_reg  <= em_left_reg - CNT_W'(chunk);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign command       = out_cmd_reg;
    assign flash_address = out_addr_reg;
    assign byte_count    = out_cnt_reg;
    assign last          = out_last_reg;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for flash_write_erase_planner: stream stimulus, random idling,
// and a scoreboard class that predicts every erase/program/reject command in order.
// Depends on rtl/fwep_pkg.sv and rtl/flash_write_erase_planner.sv, with its fwep_ctrl and fwep_datapath.

import fwep_pkg::*;

typedef struct packed
{
    logic [1:0]  command;
    logic [24:0] flash_address;
    logic [8:0]  byte_count;
    logic        last;
} flash_cmd_t;

class flash_plan_scoreboard;
    logic [CAPACITY_W-1:0]   capacity;
    bit                      active;
    logic [FIELD_ADDR_W-1:0] cur_addr;
    logic [FIELD_LEN_W-1:0]  bytes_left;
    logic [FIELD_ADDR_W-1:0] seg_start;
    logic [12:0]             seg_count;
    bit                      needs_erase;
    flash_cmd_t              pending_cmds[$];
    int                      cmds_this_item;
    int                      errors;
    int                      taken;
    int                      checked;
    int                      erase_plans;
    int                      rejects;

    function void clear_state();
        capacity    = CAPACITY_RESET;
        active      = 0;
        cur_addr    = '0;
        bytes_left  = '0;
        seg_start   = '0;
        seg_count   = '0;
        needs_erase = 0;
    endfunction

    function void set_capacity(logic [CAPACITY_W-1:0] value);
        capacity = value;
    endfunction

    function void push_cmd(logic [1:0] command, logic [24:0] addr, logic [8:0] count);
        flash_cmd_t c;
        if (cmds_this_item >= MAX_RESULTS)
            return;
        c.command       = command;
        c.flash_address = addr;
        c.byte_count    = count;
        c.last          = 1'b0;
        pending_cmds.push_back(c);
        cmds_this_item++;
    endfunction

    function void push_programs(logic [24:0] addr, int count);
        int room;
        int chunk;
        while (count > 0 && cmds_this_item < MAX_RESULTS)
        begin
            room  = PAGE_BYTES_DEF - int'(addr % PAGE_BYTES_DEF);
            chunk = (count < room) ? count : room;
            push_cmd(CMD_PROGRAM, addr, 9'(chunk));
            addr  = addr + 25'(chunk);
            count = count - chunk;
        end
    endfunction

    function void note_transaction(logic op, logic [24:0] start, logic [15:0] len,
                                   logic [7:0] new_byte, logic [7:0] old_byte);
        logic [24:0] base;
        cmds_this_item = 0;
        taken++;
        if (op == OP_BEGIN)
        begin
            active = 0;
            if (len == 0 || {1'b0, start} > capacity)
            begin
                push_cmd(CMD_REJECT, start, 9'd0);
                pending_cmds[pending_cmds.size() - 1].last = 1'b1;
                rejects++;
                return;
            end
            active      = 1;
            cur_addr    = start;
            bytes_left  = len;
            seg_start   = start;
            seg_count   = '0;
            needs_erase = 0;
            return;
        end
        if (!active)
            return;
        if ((~old_byte & new_byte) != 8'd0)
            needs_erase = 1;
        seg_count++;
        cur_addr++;
        bytes_left--;
        if (bytes_left != 0 && (cur_addr % SECTOR_BYTES_DEF) != 0)
            return;
        if (needs_erase)
        begin
            base = seg_start - 25'(seg_start % SECTOR_BYTES_DEF);
            push_cmd(CMD_ERASE, base, 9'd0);
            push_programs(base, SECTOR_BYTES_DEF);
            erase_plans++;
        end
        else
        begin
            push_programs(seg_start, int'(seg_count));
        end
        if (cmds_this_item > 0)
            pending_cmds[pending_cmds.size() - 1].last = 1'b1;
        if (bytes_left == 0)
        begin
            active = 0;
        end
        else
        begin
            seg_start   = cur_addr;
            seg_count   = '0;
            needs_erase = 0;
        end
    endfunction

    function void check_command(logic [1:0] command, logic [24:0] addr,
                                logic [8:0] count, logic last);
        flash_cmd_t e;
        checked++;
        if (pending_cmds.size() == 0)
        begin
            $display("%0t: unexpected command %0d address 0x%07h count %0d last %0d",
                     $time, command, addr, count, last);
            errors++;
            return;
        end
        e = pending_cmds.pop_front();
        if (command !== e.command)
        begin
            $display("%0t: command expected %0d got %0d", $time, e.command, command);
            errors++;
        end
        if (addr !== e.flash_address)
        begin
            $display("%0t: flash_address expected 0x%07h got 0x%07h",
                     $time, e.flash_address, addr);
            errors++;
        end
        if (count !== e.byte_count)
        begin
            $display("%0t: byte_count expected %0d got %0d", $time, e.byte_count, count);
            errors++;
        end
        if (last !== e.last)
        begin
            $display("%0t: last expected %0d got %0d", $time, e.last, last);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [25:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;     // start_address, length, new_byte, old_byte, zero pad
    logic [0:0]  s_tuser = '0;     // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // flash_address, byte_count, zero pad
    logic [1:0]  m_tuser;          // command
    logic        m_tlast;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;

    flash_plan_scoreboard sb;

    flash_write_erase_planner i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else
        begin
            m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_command(m_tuser, m_tdata[24:0], m_tdata[33:25], m_tlast);
    end

    task automatic send_item(logic op, logic [24:0] start, logic [15:0] len,
                             logic [7:0] new_byte, logic [7:0] old_byte);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {7'd0, old_byte, new_byte, len, start};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_transaction(op, start, len, new_byte, old_byte);
    endtask

    task automatic begin_request(logic [24:0] start, logic [15:0] len);
        send_item(OP_BEGIN, start, len, 8'($urandom), 8'($urandom));
    endtask

    task automatic data_byte(logic [7:0] new_byte, logic [7:0] old_byte);
        send_item(OP_DATA, 25'($urandom), 16'($urandom), new_byte, old_byte);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_capacity(logic [25:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.set_capacity(value);
    endtask

    task automatic random_request();
        logic [24:0] limit;
        logic [24:0] start;
        logic [15:0] len;
        logic [7:0]  new_byte;
        logic [7:0]  old_byte;
        int          style;
        int          count;
        limit = (sb.capacity > 26'h1FFFFFF) ? 25'h1FFFFFF : sb.capacity[24:0];
        start = 25'($urandom_range(0, int'(limit)));
        if ($urandom_range(0, 1) == 1)
        begin
            start = {start[24:12], 12'hFFF} - 25'($urandom_range(0, 47));
            if (start > limit)
                start = limit;
        end
        if ($urandom_range(0, 14) == 0)
            len = 16'($urandom_range(25, 300));
        else
            len = 16'($urandom_range(1, 24));
        count = int'(len);
        if ($urandom_range(0, 9) == 0)
            count = $urandom_range(0, int'(len) - 1);
        style = $urandom_range(0, 2);
        begin_request(start, len);
        for (int i = 0; i < count; i++)
        begin
            old_byte = 8'($urandom);
            new_byte = 8'($urandom);
            if (style == 0)
                new_byte = old_byte & new_byte;
            else if (style == 2 && $urandom_range(0, 19) != 0)
                new_byte = old_byte;
            data_byte(new_byte, old_byte);
        end
    endtask

    task automatic noise_items();
        begin_request(25'($urandom), 16'($urandom));
        repeat ($urandom_range(0, 3))
            data_byte(8'($urandom), 8'($urandom));
    endtask

    task automatic run_phase(logic [25:0] capacity, int idle_pct, int stall_pct,
                             int n_items, bit long_hold);
        int target;
        wait_drain();
        write_capacity(capacity);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = sb.taken + n_items;
        if (long_hold)
        begin
            hold_left = 400;
            begin_request(25'h010FF0, 16'd48);
            repeat (48)
                data_byte(8'($urandom), 8'($urandom));
        end
        while (sb.taken < target)
        begin
            if ($urandom_range(0, 99) < 80)
                random_request();
            else
                noise_items();
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear_state();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        begin_request(25'h0000123, 16'd0);
        begin_request(25'(CAPACITY_RESET) + 25'd1, 16'd5);
        data_byte(8'hFF, 8'h00);
        begin_request(25'(CAPACITY_RESET), 16'd1);
        data_byte(8'h00, 8'hFF);
        begin_request(25'h00000FE, 16'd4);
        repeat (4) data_byte(8'h5A, 8'h5A);
        begin_request(25'h0003FFE, 16'd3);
        data_byte(8'hFF, 8'h00);
        data_byte(8'h00, 8'h00);
        data_byte(8'h00, 8'h00);
        begin_request(25'h0005000, 16'hFFFF);
        data_byte(8'h12, 8'h34);
        begin_request(25'h0007000, 16'd2);
        data_byte(8'h00, 8'hFF);
        data_byte(8'h81, 8'hFF);
        wait_drain();
        write_capacity(26'h2000000);
        begin_request(25'h1FFFFFE, 16'd3);
        data_byte(8'h01, 8'h00);
        data_byte(8'h00, 8'h00);
        data_byte(8'h00, 8'h00);
        begin_request(25'h1FFFFFF, 16'd1);
        data_byte(8'h0F, 8'h0F);

        run_phase(26'h2000000, 0, 0, 70, 1'b1);
        run_phase(26'h0000000, 45, 0, 50, 1'b0);
        run_phase(26'($urandom_range(4096, 33554432)), 0, 45, 80, 1'b0);
        run_phase(CAPACITY_RESET, 33, 33, 80, 1'b0);

        wait_drain();
        repeat (60) @(posedge clk);
        $display("Accepted %0d transactions over several capacity settings and four idling mixes.",
                 sb.taken);
        $display("Checked %0d commands, including %0d erase plans and %0d rejected requests.",
                 sb.checked, sb.erase_plans, sb.rejects);
        if (sb.errors == 0 && sb.pending_cmds.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
